>>> rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg: shared types for the first-fit block allocator
// Sequencer state encoding used by the top level and its assertions.
// ----------------------------------------------------------------------------
`default_nettype none

package bffa_pkg;

    // Field widths of the stream payloads
    localparam int BYTES_W = 12;
    localparam int OFFS_W  = 11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } t_state;

    // Operation codes carried on the input tuser
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage

`default_nettype wire

>>> rtl/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/bitmap_first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator: first-fit contiguous block allocator
// Keeps one used bit per pool block and serves allocate and free requests.
// ----------------------------------------------------------------------------
// Input stream: tuser = func (0 allocate, 1 free); tdata = byte_count and
// free_offset. Output stream: tuser = success; tdata = granted_bytes and
// buffer_offset. One result per request.
// An allocate scans the used map one block per cycle from block 0 until a
// free run covers the request, then marks the run one block per cycle. The
// result then passes through ST_DONE into the output register. A failed
// allocate scans the whole map; a zero-byte allocate skips the scan and
// goes straight to ST_DONE. A free walks the whole map, one block per
// cycle. Ready returns the cycle after the result loads, so a new request
// is taken only after the last result has loaded.
// The used map sits in a single-port-write RAM with registered read, and the
// scan, mark and free walks share its one write and one read port; the scan
// and free walks also share one byte accumulator adder. One request is in
// flight at a time; ready stays low from acceptance until the result moves
// to the output register.
// After reset a clearing pass writes every map entry to free, with ready low.
// A stalled receiver holds the result in the output register; the block
// still takes and processes the next request and waits with its result
// until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_first_fit_block_allocator #(
    parameter int POOL_BLOCKS = 64,
    parameter int BLOCK_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [11:0] byte_count, [22:12] free_offset, [23] zero
    input  wire logic        s_axis_tuser,   // [0] func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // [11:0] granted_bytes, [22:12] buffer_offset, [23] zero
    output logic             m_axis_tuser    // [0] success
);

    import bffa_pkg::*;

    localparam int IW       = $clog2(POOL_BLOCKS);
    localparam int POOL_SZ  = POOL_BLOCKS * BLOCK_BYTES;
    localparam int PW_RAW   = $clog2(POOL_SZ + 1);
    localparam int PW       = (PW_RAW > BYTES_W + 1) ? PW_RAW : BYTES_W + 1;
    localparam logic [PW-1:0] BLK      = PW'(BLOCK_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_BLOCKS - 1);

    t_state r_state, n_state;

    logic [IW-1:0]      r_idx, n_idx;
    logic [PW-1:0]      r_pos, n_pos;
    logic [IW-1:0]      r_run_idx, n_run_idx;
    logic [PW-1:0]      r_run_pos, n_run_pos;
    logic [PW-1:0]      r_acc, n_acc;
    logic [IW:0]        r_run_len, n_run_len;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [OFFS_W-1:0]  r_offs, n_offs;

    logic               r_res_ok, n_res_ok;
    logic [BYTES_W-1:0] r_res_grant, n_res_grant;
    logic [OFFS_W-1:0]  r_res_offs, n_res_offs;

    logic               r_out_vld, n_out_vld;
    logic               r_out_ok, n_out_ok;
    logic [BYTES_W-1:0] r_out_grant, n_out_grant;
    logic [OFFS_W-1:0]  r_out_offs, n_out_offs;

    logic               w_we;
    logic               w_wdata;
    logic [IW-1:0]      w_waddr;
    logic               w_used;
    logic               w_in_xfer;
    logic [PW-1:0]      w_pos_nxt;
    logic [PW-1:0]      w_acc_sum;
    logic [PW-1:0]      w_bytes_ext;
    logic [PW-1:0]      w_offs_ext;

    // Read address follows the next index so data lines up with r_idx
    bffa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_BLOCKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_used)
    );

    assign w_in_xfer   = s_axis_tvalid && s_axis_tready;
    assign w_pos_nxt   = r_pos + BLK;
    assign w_acc_sum   = r_acc + BLK;     // shared byte accumulator
    assign w_bytes_ext = PW'(r_bytes);
    assign w_offs_ext  = PW'(r_offs);

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {1'b0, r_out_offs, r_out_grant};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_run_idx   <= n_run_idx;
        r_run_pos   <= n_run_pos;
        r_acc       <= n_acc;
        r_run_len   <= n_run_len;
        r_bytes     <= n_bytes;
        r_offs      <= n_offs;
        r_res_ok    <= n_res_ok;
        r_res_grant <= n_res_grant;
        r_res_offs  <= n_res_offs;
        r_out_ok    <= n_out_ok;
        r_out_grant <= n_out_grant;
        r_out_offs  <= n_out_offs;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_run_idx   = r_run_idx;
        n_run_pos   = r_run_pos;
        n_acc       = r_acc;
        n_run_len   = r_run_len;
        n_bytes     = r_bytes;
        n_offs      = r_offs;
        n_res_ok    = r_res_ok;
        n_res_grant = r_res_grant;
        n_res_offs  = r_res_offs;
        n_out_vld   = r_out_vld;
        n_out_ok    = r_out_ok;
        n_out_grant = r_out_grant;
        n_out_offs  = r_out_offs;
        w_we        = 1'b0;
        w_wdata     = 1'b0;
        w_waddr     = r_idx;

        // Drop the output entry once its transfer completes
        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_bytes   = s_axis_tdata[BYTES_W-1:0];
                    n_offs    = s_axis_tdata[BYTES_W +: OFFS_W];
                    n_idx     = '0;
                    n_pos     = '0;
                    n_run_idx = '0;
                    n_run_pos = '0;
                    n_acc     = '0;
                    n_run_len = '0;
                    if (s_axis_tuser == FUNC_FREE) begin
                        n_state = ST_FREE;
                    end else if (s_axis_tdata[BYTES_W-1:0] == '0) begin
                        n_res_ok    = 1'b0;
                        n_res_grant = '0;
                        n_res_offs  = '0;
                        n_state     = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_idx = r_idx + 1'b1;
                n_pos = w_pos_nxt;
                if (w_used) begin
                    // Restart the run just past this block
                    n_acc     = '0;
                    n_run_len = '0;
                    n_run_idx = r_idx + 1'b1;
                    n_run_pos = w_pos_nxt;
                end else begin
                    n_acc     = w_acc_sum;
                    n_run_len = r_run_len + 1'b1;
                end
                if (!w_used && (w_acc_sum >= w_bytes_ext)) begin
                    n_res_ok    = 1'b1;
                    n_res_grant = w_acc_sum[BYTES_W-1:0];
                    n_res_offs  = r_run_pos[OFFS_W-1:0];
                    n_idx       = r_run_idx;
                    n_state     = ST_MARK;
                end else if (r_idx == LAST_IDX) begin
                    n_res_ok    = 1'b0;
                    n_res_grant = '0;
                    n_res_offs  = '0;
                    n_state     = ST_DONE;
                end
            end
            ST_MARK: begin
                w_we      = 1'b1;
                w_wdata   = 1'b1;
                n_idx     = r_idx + 1'b1;
                n_run_len = r_run_len - 1'b1;
                if (r_run_len == (IW+1)'(1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_FREE: begin
                n_idx = r_idx + 1'b1;
                n_pos = w_pos_nxt;
                // Block lies at or after the first freed block and inside the size
                if ((w_pos_nxt > w_offs_ext) && (w_acc_sum <= w_bytes_ext)) begin
                    w_we  = 1'b1;
                    n_acc = w_acc_sum;
                end
                if (r_idx == LAST_IDX) begin
                    n_res_ok    = 1'b1;
                    n_res_grant = '0;
                    n_res_offs  = '0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld   = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_grant = r_res_grant;
                    n_out_offs  = r_res_offs;
                    n_idx       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // A failed or free result never carries a size; a failure carries no offset
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("failed allocation reports nonzero size or offset");

    // Map writes happen only in the clearing, marking and freeing walks
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_CLEAR || r_state == ST_MARK || r_state == ST_FREE))
        else $error("map written outside a write walk");

    // No request is taken on the first cycle after reset: the clearing pass runs
    a_clear_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !s_axis_tready)
        else $error("ready raised before the map was cleared");

endmodule

`default_nettype wire
